// ===== rtl/tbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Tilt bubble position package
// Field widths, register indexes and reset values shared by the channel
// interfaces and the tilt bubble position block.
// ---------------------------------------------------------------------------
package tbp_pkg;

   // Payload field widths.
   localparam int ACCEL_W = 32;
   localparam int POS_W   = 12;

   // Configuration port shape.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Register widths.
   localparam int ORIGIN_W    = 10;
   localparam int RADIUS_W    = 8;
   localparam int THRESHOLD_W = 16;

   // Fixed-point format of the normalized tilt.
   localparam int Q15_FRAC = 15;
   localparam int NORM_W   = 16;

   // Width of the smoothed pixel offsets.
   localparam int SMOOTH_W = 10;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAVEL_RADIUS   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_THRESHOLD = 2'd3;

   // Register reset values.
   localparam logic [ORIGIN_W-1:0]    ORIGIN_X_RST        = 10'd96;
   localparam logic [ORIGIN_W-1:0]    ORIGIN_Y_RST        = 10'd96;
   localparam logic [RADIUS_W-1:0]    TRAVEL_RADIUS_RST   = 8'd94;
   localparam logic [THRESHOLD_W-1:0] LEVEL_THRESHOLD_RST = 16'd819;

endpackage : tbp_pkg
`default_nettype wire

// ===== rtl/tbp_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one accelerometer sample per beat.
// ---------------------------------------------------------------------------
interface tbp_req_if
   import tbp_pkg::*;
   ();

   logic                      valid;
   logic                      ready;
   logic signed [ACCEL_W-1:0] accel_x;
   logic signed [ACCEL_W-1:0] accel_y;
   logic signed [ACCEL_W-1:0] accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                   output ready);

endinterface : tbp_req_if
`default_nettype wire

// ===== rtl/tbp_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Position channel
// Valid/ready channel that carries one bubble position per beat.
// ---------------------------------------------------------------------------
interface tbp_rsp_if
   import tbp_pkg::*;
   ();

   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic                    is_level;

   modport source (output valid, output pos_x, output pos_y, output is_level,
                   input ready);
   modport sink   (input valid, input pos_x, input pos_y, input is_level,
                   output ready);

endinterface : tbp_rsp_if
`default_nettype wire

// ===== rtl/tilt_bubble_position_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Tilt bubble position unit
// Turns one accelerometer sample into a smoothed spirit-level bubble position.
// ---------------------------------------------------------------------------
// Usage:
//   Samples arrive on req_bus; a beat is taken when valid and ready are high.
//   Each sample that is not all zero yields one beat on rsp_bus with the
//   bubble position and the level flag; an all-zero sample yields nothing and
//   leaves the smoothing state alone.
//   The block works on one sample at a time and holds req_bus.ready low while
//   busy. Its work runs on the shared restoring subtractor: 16 steps for each
//   Q15 normalization and, only when the offset is pulled back onto the circle,
//   9 steps of the square root and 8 steps for each clamp division, with
//   steps on the shared 16x8 multiplier between them. The result sits in an
//   output register; the block is ready the cycle after and takes the next
//   sample while it waits. If the receiver stalls, the following result waits
//   in its final step until the register is free.
//   Configuration writes on csr_we/csr_index/csr_data take effect at once and
//   belong in idle periods.
//   Synchronous reset restores the register defaults, clears the smoothed
//   offsets and drops any result not yet taken.
// ---------------------------------------------------------------------------
module tilt_bubble_position_unit
   import tbp_pkg::*;
   (
   input  wire logic                   clock,
   input  wire logic                   reset,
   tbp_req_if.sink                     req_bus,
   tbp_rsp_if.source                   rsp_bus,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
   );

   // Sequencer states.
   typedef enum logic [10:0] {
      ST_IDLE       = 11'b000_0000_0001,
      ST_MAG        = 11'b000_0000_0010,
      ST_DIVX       = 11'b000_0000_0100,
      ST_DIVY       = 11'b000_0000_1000,
      ST_SCALE      = 11'b000_0001_0000,
      ST_SQUARE     = 11'b000_0010_0000,
      ST_CHECK      = 11'b000_0100_0000,
      ST_SQRT       = 11'b000_1000_0000,
      ST_CLAMP_LOAD = 11'b001_0000_0000,
      ST_CLAMP_DIV  = 11'b010_0000_0000,
      ST_SMOOTH     = 11'b100_0000_0000
   } state_type;

   localparam int MAG_W  = ACCEL_W + 1;
   localparam int SUB_W  = MAG_W + 1;
   localparam int TGT_W  = RADIUS_W;
   localparam int PROD_W = NORM_W + RADIUS_W;
   localparam int SQ_W   = 2 * TGT_W + 1;
   localparam int ROOT_W = TGT_W + 1;
   localparam int CNT_W  = 4;

   localparam logic [CNT_W-1:0] Q15_STEPS_M1   = CNT_W'(NORM_W - 1);
   localparam logic [CNT_W-1:0] SQRT_STEPS_M1  = CNT_W'(SQ_W / 2);
   localparam logic [CNT_W-1:0] CLAMP_STEPS_M1 = CNT_W'(TGT_W - 1);
   localparam logic [SQ_W-1:0]  SQRT_TOP_BIT   = SQ_W'(1) << (SQ_W - 1);

   // Configuration registers.
   logic [ORIGIN_W-1:0]    origin_x_ff, origin_x_in;
   logic [ORIGIN_W-1:0]    origin_y_ff, origin_y_in;
   logic [RADIUS_W-1:0]    radius_ff, radius_in;
   logic [THRESHOLD_W-1:0] threshold_ff, threshold_in;

   // Sequencer and smoothing state.
   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       axis_ff, axis_in;
   logic signed [SMOOTH_W-1:0] smooth_x_ff, smooth_x_in;
   logic signed [SMOOTH_W-1:0] smooth_y_ff, smooth_y_in;

   // Working registers of one sample.
   logic [ACCEL_W-1:0] ax_ff, ax_in;
   logic [ACCEL_W-1:0] ay_ff, ay_in;
   logic [ACCEL_W-1:0] az_ff, az_in;
   logic               neg_x_ff, neg_x_in;
   logic               neg_y_ff, neg_y_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [MAG_W-1:0]   rem_ff, rem_in;
   logic [NORM_W-1:0]  dlo_ff, dlo_in;
   logic [NORM_W-1:0]  quo_ff, quo_in;
   logic [NORM_W-1:0]  nxm_ff, nxm_in;
   logic [NORM_W-1:0]  nym_ff, nym_in;
   logic [TGT_W-1:0]   txm_ff, txm_in;
   logic [TGT_W-1:0]   tym_ff, tym_in;
   logic [SQ_W-1:0]    d2_ff, d2_in;
   logic [SQ_W-1:0]    res_ff, res_in;
   logic [SQ_W-1:0]    bit_ff, bit_in;
   logic [ROOT_W-1:0]  root_ff, root_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0] pos_y_ff, pos_y_in;
   logic                    level_ff, level_in;

   // Shared datapath signals.
   logic                    req_fire;
   logic                    out_free;
   logic [NORM_W-1:0]       mul_a;
   logic [RADIUS_W-1:0]     mul_b;
   logic [PROD_W-1:0]       mul_p;
   logic [SUB_W-1:0]        sub_a;
   logic [SUB_W-1:0]        sub_b;
   logic [SUB_W:0]          sub_diff;
   logic                    sub_ge;
   logic [SQ_W:0]           sq_trial;
   logic [MAG_W-1:0]        div_rem_nx;
   logic [NORM_W-1:0]       div_quo_nx;
   logic [SQ_W-1:0]         sq_v_nx;
   logic [SQ_W-1:0]         sq_res_nx;
   logic [TGT_W-1:0]        clamp_t;
   logic [2*TGT_W-1:0]      clamp_b;
   logic signed [TGT_W:0]   tgt_x;
   logic signed [TGT_W:0]   tgt_y;
   logic signed [SMOOTH_W-1:0] new_x;
   logic signed [SMOOTH_W-1:0] new_y;

   // (5*old + 3*target) / 8, truncated toward zero.
   function automatic logic signed [SMOOTH_W-1:0] smooth_step(
      input logic signed [SMOOTH_W-1:0] old_v,
      input logic signed [TGT_W:0]      tgt_v);
      logic signed [SMOOTH_W+2:0] sum_v;
      logic signed [SMOOTH_W+2:0] adj_v;
      sum_v = ((SMOOTH_W+3)'(old_v) <<< 2) + (SMOOTH_W+3)'(old_v)
            + ((SMOOTH_W+3)'(tgt_v) <<< 1) + (SMOOTH_W+3)'(tgt_v);
      adj_v = sum_v[SMOOTH_W+2] ? sum_v + (SMOOTH_W+3)'(7) : sum_v;
      smooth_step = SMOOTH_W'(adj_v >>> 3);
   endfunction

   // Sign applied to a pixel offset magnitude.
   function automatic logic signed [TGT_W:0] apply_sign(
      input logic             neg_v,
      input logic [TGT_W-1:0] mag_v);
      logic signed [TGT_W:0] pos_v;
      pos_v = $signed({1'b0, mag_v});
      apply_sign = neg_v ? -pos_v : pos_v;
   endfunction

   // Handshakes.
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.pos_x    = pos_x_ff;
   assign rsp_bus.pos_y    = pos_y_ff;
   assign rsp_bus.is_level = level_ff;

   // Configuration writes.
   always_comb begin
      origin_x_in  = origin_x_ff;
      origin_y_in  = origin_y_ff;
      radius_in    = radius_ff;
      threshold_in = threshold_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X:        origin_x_in  = csr_data[ORIGIN_W-1:0];
            CSR_ORIGIN_Y:        origin_y_in  = csr_data[ORIGIN_W-1:0];
            CSR_TRAVEL_RADIUS:   radius_in    = csr_data[RADIUS_W-1:0];
            CSR_LEVEL_THRESHOLD: threshold_in = csr_data[THRESHOLD_W-1:0];
            default:             origin_x_in  = origin_x_ff;
         endcase
      end
   end

   // Shared multiplier operand selection.
   always_comb begin
      clamp_t = axis_ff ? tym_ff : txm_ff;
      mul_a   = {(NORM_W-TGT_W)'(0), clamp_t};
      mul_b   = radius_ff;
      case (state_ff)
         ST_SCALE:  mul_a = axis_ff ? nym_ff : nxm_ff;
         ST_SQUARE: mul_b = clamp_t;
         ST_CHECK:  mul_a = {(NORM_W-RADIUS_W)'(0), radius_ff};
         default:   mul_a = {(NORM_W-TGT_W)'(0), clamp_t};
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign clamp_b = mul_p[2*TGT_W-1:0];

   // Shared restoring subtractor: divider step or square-root step.
   assign sq_trial = {1'b0, res_ff} + {1'b0, bit_ff};

   always_comb begin
      sub_a = {rem_ff, dlo_ff[NORM_W-1]};
      sub_b = {1'b0, mag_ff};
      case (state_ff)
         ST_CLAMP_DIV: sub_b = {(SUB_W-ROOT_W)'(0), root_ff};
         ST_SQRT: begin
            sub_a = {(SUB_W-SQ_W)'(0), rem_ff[SQ_W-1:0]};
            sub_b = {(SUB_W-SQ_W-1)'(0), sq_trial};
         end
         default: sub_b = {1'b0, mag_ff};
      endcase
   end

   assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge     = !sub_diff[SUB_W];
   assign div_rem_nx = sub_ge ? sub_diff[MAG_W-1:0] : sub_a[MAG_W-1:0];
   assign div_quo_nx = {quo_ff[NORM_W-2:0], sub_ge};
   assign sq_v_nx    = sub_ge ? sub_diff[SQ_W-1:0] : rem_ff[SQ_W-1:0];
   assign sq_res_nx  = sub_ge ? (res_ff >> 1) + bit_ff : res_ff >> 1;

   // Smoothing of the final targets.
   assign tgt_x = apply_sign(neg_x_ff, txm_ff);
   assign tgt_y = apply_sign(neg_y_ff, tym_ff);
   assign new_x = smooth_step(smooth_x_ff, tgt_x);
   assign new_y = smooth_step(smooth_y_ff, tgt_y);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      smooth_x_in  = smooth_x_ff;
      smooth_y_in  = smooth_y_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      dlo_in       = dlo_ff;
      quo_in       = quo_ff;
      nxm_in       = nxm_ff;
      nym_in       = nym_ff;
      txm_in       = txm_ff;
      tym_in       = tym_ff;
      d2_in        = d2_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      level_in     = level_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ax_in    = req_bus.accel_x[ACCEL_W-1] ? -req_bus.accel_x : req_bus.accel_x;
               ay_in    = req_bus.accel_y[ACCEL_W-1] ? -req_bus.accel_y : req_bus.accel_y;
               az_in    = req_bus.accel_z[ACCEL_W-1] ? -req_bus.accel_z : req_bus.accel_z;
               neg_x_in = req_bus.accel_x[ACCEL_W-1];
               neg_y_in = !req_bus.accel_y[ACCEL_W-1];
               state_in = ST_MAG;
            end
         end

         // L1 magnitude; the x division is loaded alongside.
         ST_MAG: begin
            mag_in = {1'b0, ax_ff} + {1'b0, ay_ff} + {1'b0, az_ff};
            rem_in = {2'b00, ax_ff[ACCEL_W-1:1]};
            dlo_in = {ax_ff[0], (NORM_W-1)'(0)};
            quo_in = '0;
            cnt_in = Q15_STEPS_M1;
            if (ax_ff == '0 && ay_ff == '0 && az_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DIVX;
            end
         end

         ST_DIVX: begin
            rem_in = div_rem_nx;
            dlo_in = dlo_ff << 1;
            quo_in = div_quo_nx;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               nxm_in   = div_quo_nx;
               rem_in   = {2'b00, ay_ff[ACCEL_W-1:1]};
               dlo_in   = {ay_ff[0], (NORM_W-1)'(0)};
               quo_in   = '0;
               cnt_in   = Q15_STEPS_M1;
               state_in = ST_DIVY;
            end
         end

         ST_DIVY: begin
            rem_in = div_rem_nx;
            dlo_in = dlo_ff << 1;
            quo_in = div_quo_nx;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               nym_in   = div_quo_nx;
               axis_in  = 1'b0;
               state_in = ST_SCALE;
            end
         end

         // Pixel offsets: n * radius / 2^15.
         ST_SCALE: begin
            if (axis_ff) begin
               tym_in   = mul_p[Q15_FRAC+TGT_W-1:Q15_FRAC];
               axis_in  = 1'b0;
               state_in = ST_SQUARE;
            end else begin
               txm_in  = mul_p[Q15_FRAC+TGT_W-1:Q15_FRAC];
               axis_in = 1'b1;
            end
         end

         // Squared distance.
         ST_SQUARE: begin
            if (axis_ff) begin
               d2_in    = d2_ff + {1'b0, mul_p[2*TGT_W-1:0]};
               axis_in  = 1'b0;
               state_in = ST_CHECK;
            end else begin
               d2_in   = {1'b0, mul_p[2*TGT_W-1:0]};
               axis_in = 1'b1;
            end
         end

         // Compare against radius squared; start the root if outside.
         ST_CHECK: begin
            if (d2_ff > {1'b0, mul_p[2*RADIUS_W-1:0]}) begin
               rem_in   = {(MAG_W-SQ_W)'(0), d2_ff};
               res_in   = '0;
               bit_in   = SQRT_TOP_BIT;
               cnt_in   = SQRT_STEPS_M1;
               state_in = ST_SQRT;
            end else begin
               state_in = ST_SMOOTH;
            end
         end

         ST_SQRT: begin
            rem_in = {(MAG_W-SQ_W)'(0), sq_v_nx};
            res_in = sq_res_nx;
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               root_in  = sq_res_nx[ROOT_W-1:0];
               axis_in  = 1'b0;
               state_in = ST_CLAMP_LOAD;
            end
         end

         // Load t * radius into the divider; the quotient stays below 2^8.
         ST_CLAMP_LOAD: begin
            rem_in   = {(MAG_W-TGT_W)'(0), clamp_b[2*TGT_W-1:TGT_W]};
            dlo_in   = {clamp_b[TGT_W-1:0], (NORM_W-TGT_W)'(0)};
            quo_in   = '0;
            cnt_in   = CLAMP_STEPS_M1;
            state_in = ST_CLAMP_DIV;
         end

         ST_CLAMP_DIV: begin
            rem_in = div_rem_nx;
            dlo_in = dlo_ff << 1;
            quo_in = div_quo_nx;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (axis_ff) begin
                  tym_in   = div_quo_nx[TGT_W-1:0];
                  state_in = ST_SMOOTH;
               end else begin
                  txm_in   = div_quo_nx[TGT_W-1:0];
                  axis_in  = 1'b1;
                  state_in = ST_CLAMP_LOAD;
               end
            end
         end

         // Update the smoothed offsets and post the result.
         ST_SMOOTH: begin
            if (out_free) begin
               smooth_x_in  = new_x;
               smooth_y_in  = new_y;
               pos_x_in     = $signed({2'b00, origin_x_ff})
                            + $signed({{(POS_W-SMOOTH_W){new_x[SMOOTH_W-1]}}, new_x});
               pos_y_in     = $signed({2'b00, origin_y_ff})
                            + $signed({{(POS_W-SMOOTH_W){new_y[SMOOTH_W-1]}}, new_y});
               level_in     = (nxm_ff < threshold_ff) && (nym_ff < threshold_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= ORIGIN_X_RST;
         origin_y_ff  <= ORIGIN_Y_RST;
         radius_ff    <= TRAVEL_RADIUS_RST;
         threshold_ff <= LEVEL_THRESHOLD_RST;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= 1'b0;
         smooth_x_ff  <= '0;
         smooth_y_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         radius_ff    <= radius_in;
         threshold_ff <= threshold_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         smooth_x_ff  <= smooth_x_in;
         smooth_y_ff  <= smooth_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      az_ff    <= az_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      mag_ff   <= mag_in;
      rem_ff   <= rem_in;
      dlo_ff   <= dlo_in;
      quo_ff   <= quo_in;
      nxm_ff   <= nxm_in;
      nym_ff   <= nym_in;
      txm_ff   <= txm_in;
      tym_ff   <= tym_in;
      d2_ff    <= d2_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      root_ff  <= root_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      level_ff <= level_in;
   end

`ifndef ASSERT_OFF
   // An accepted sample always starts with the magnitude step.
   a_accept_to_mag: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_MAG))
      else $error("accepted sample did not enter the magnitude step");

   // The clamp divisor is the root of a distance above the radius, never zero.
   a_clamp_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLAMP_DIV) |-> (root_ff != '0))
      else $error("clamp division started with a zero divisor");

   // A normalized tilt never exceeds one in Q15.
   a_q15_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> (nxm_ff <= 16'd32768 && nym_ff <= 16'd32768))
      else $error("normalized tilt out of range");

   // Finishing a sample with a free output register posts a result beat.
   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SMOOTH && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished sample did not post a result beat");
`endif

endmodule : tilt_bubble_position_unit
`default_nettype wire

// ===== tb/sv/tb_tilt_bubble_position_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tilt bubble position unit testbench
// Feeds accelerometer samples through the sample channel under random gaps
// and back-pressure, predicts each bubble position and level flag with a
// local integer model of the normalize, scale, clamp and smoothing chain,
// and checks every position beat field by field across several register
// settings, the extremes among them.
// ---------------------------------------------------------------------------
module tb_tilt_bubble_position_unit;
   import tbp_pkg::*;

   localparam int    CLK_PERIOD     = 10;
   localparam int    RESET_CYCLES   = 5;
   localparam int    IDLE_PCT       = 21;
   localparam int    SETTLE_CYCLES  = 80;
   localparam int    WATCHDOG_LIMIT = 3000;
   localparam int    EXTREME_ITEMS  = 60;
   localparam int    RANDOM_ITEMS   = 100;
   localparam int    RANDOM_PHASES  = 6;
   localparam int    STEADY_PHASE   = 3;
   localparam longint Q15_ONE       = longint'(1) << Q15_FRAC;
   // Smoothing weights: new = (5*old + 3*target) / 8.
   localparam longint KEEP_WEIGHT   = 5;
   localparam longint TAKE_WEIGHT   = 3;
   localparam longint WEIGHT_SUM    = 8;

   localparam logic signed [ACCEL_W-1:0] ACCEL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [ACCEL_W-1:0] ACCEL_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [ACCEL_W-1:0] x;
      logic signed [ACCEL_W-1:0] y;
      logic signed [ACCEL_W-1:0] z;
   } sample_type;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic             level;
   } bubble_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   tbp_req_if req_bus ();
   tbp_rsp_if rsp_bus ();

   tilt_bubble_position_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Local copy of the registers and of the smoothed offsets.
   logic [ORIGIN_W-1:0]    origin_x_reg;
   logic [ORIGIN_W-1:0]    origin_y_reg;
   logic [RADIUS_W-1:0]    radius_reg;
   logic [THRESHOLD_W-1:0] threshold_reg;
   longint                 smooth_x;
   longint                 smooth_y;

   sample_type sample_queue[$];
   bubble_type bubble_queue[$];

   logic sample_taken = 1'b0;
   logic steady_run   = 1'b0;
   int   fail_count   = 0;
   int   sample_beats = 0;
   int   zero_samples = 0;
   int   bubble_beats = 0;
   int   level_beats  = 0;
   int   settings     = 0;
   int   stall_cycles = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Advances the smoothed bubble by one sample; returns 0 for an all-zero sample.
   function automatic bit advance_bubble(input sample_type s, output bubble_type b);
      longint ax, ay, az, mag, nx, ny, tx, ty, r, d2, root;
      ax  = longint'(s.x);
      ay  = longint'(s.y);
      az  = longint'(s.z);
      mag = magnitude(ax) + magnitude(ay) + magnitude(az);
      b   = '0;
      if (mag == 0) begin
         return 1'b0;
      end
      // Q15 tilt, with the y axis flipped.
      nx = (ax * Q15_ONE) / mag;
      ny = (-ay * Q15_ONE) / mag;
      r  = longint'(radius_reg);
      tx = (nx * r) / Q15_ONE;
      ty = (ny * r) / Q15_ONE;
      // Pull the target back onto the travel circle when it lies outside.
      d2 = tx * tx + ty * ty;
      if (d2 > r * r) begin
         root = 0;
         while ((root + 1) * (root + 1) <= d2) begin
            root++;
         end
         if (root > 0) begin
            tx = (tx * r) / root;
            ty = (ty * r) / root;
         end
      end
      smooth_x = (smooth_x * KEEP_WEIGHT + tx * TAKE_WEIGHT) / WEIGHT_SUM;
      smooth_y = (smooth_y * KEEP_WEIGHT + ty * TAKE_WEIGHT) / WEIGHT_SUM;
      b.pos_x  = POS_W'(longint'(origin_x_reg) + smooth_x);
      b.pos_y  = POS_W'(longint'(origin_y_reg) + smooth_y);
      b.level  = (magnitude(nx) < longint'(threshold_reg)) &&
                 (magnitude(ny) < longint'(threshold_reg));
      return 1'b1;
   endfunction

   function automatic logic signed [ACCEL_W-1:0] corner_value();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 1;
         2: return -1;
         3: return ACCEL_MAX;
         4: return ACCEL_MIN;
         default: return $urandom;
      endcase
   endfunction

   // Mix of all-zero, nearly level, corner-valued and fully random samples.
   function automatic sample_type random_sample();
      sample_type s;
      int         roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         s = '0;
      end else if (roll < 28) begin
         s.x = $signed($urandom_range(0, 4000)) - 2000;
         s.y = $signed($urandom_range(0, 4000)) - 2000;
         s.z = $urandom | 32'h1000_0000;
      end else if (roll < 40) begin
         s.x = corner_value();
         s.y = corner_value();
         s.z = corner_value();
      end else begin
         s.x = $urandom;
         s.y = $urandom;
         s.z = $urandom;
      end
      return s;
   endfunction

   function automatic sample_type make_sample(input longint x, input longint y, input longint z);
      sample_type s;
      s.x = x[ACCEL_W-1:0];
      s.y = y[ACCEL_W-1:0];
      s.z = z[ACCEL_W-1:0];
      return s;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= CSR_DATA_W'(value);
   endtask

   // Writes all four registers while the block is idle.
   task automatic program_bubble(input int ox, input int oy, input int radius, input int thr);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_TRAVEL_RADIUS, radius);
      write_reg(CSR_LEVEL_THRESHOLD, thr);
      @(negedge clock);
      csr_we        <= 1'b0;
      origin_x_reg  = ORIGIN_W'(ox);
      origin_y_reg  = ORIGIN_W'(oy);
      radius_reg    = RADIUS_W'(radius);
      threshold_reg = THRESHOLD_W'(thr);
      settings++;
   endtask

   // Waits until every sample is taken and every position has come back.
   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (sample_queue.size() != 0 || req_bus.valid || bubble_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      repeat (count) sample_queue.push_back(random_sample());
   endtask

   // Sample driver: presents the next queued beat once the previous one is taken.
   always @(negedge clock) begin : sample_driver
      sample_type next_sample;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || sample_taken) begin
         if (sample_queue.size() != 0 && (steady_run || $urandom_range(0, 99) >= IDLE_PCT)) begin
            next_sample = sample_queue.pop_front();
            req_bus.valid   <= 1'b1;
            req_bus.accel_x <= next_sample.x;
            req_bus.accel_y <= next_sample.y;
            req_bus.accel_z <= next_sample.z;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Position receiver back-pressure.
   always @(negedge clock) begin : position_sink
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Monitor: predicts on each sample beat and checks each position beat.
   always @(posedge clock) begin : bubble_monitor
      sample_type s;
      bubble_type want;
      if (reset) begin
         sample_taken <= 1'b0;
      end else begin
         sample_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            s = make_sample(longint'(req_bus.accel_x), longint'(req_bus.accel_y),
                            longint'(req_bus.accel_z));
            sample_beats++;
            if (advance_bubble(s, want)) begin
               bubble_queue.push_back(want);
            end else begin
               zero_samples++;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            bubble_beats++;
            if (rsp_bus.is_level) begin
               level_beats++;
            end
            if (bubble_queue.size() == 0) begin
               $error("position beat arrived with no position expected");
               fail_count++;
            end else begin
               want = bubble_queue.pop_front();
               if (rsp_bus.pos_x !== want.pos_x) begin
                  $error("pos_x mismatch: expected %0d, got %0d",
                         $signed(want.pos_x), rsp_bus.pos_x);
                  fail_count++;
               end
               if (rsp_bus.pos_y !== want.pos_y) begin
                  $error("pos_y mismatch: expected %0d, got %0d",
                         $signed(want.pos_y), rsp_bus.pos_y);
                  fail_count++;
               end
               if (rsp_bus.is_level !== want.level) begin
                  $error("is_level mismatch: expected %0d, got %0d",
                         want.level, rsp_bus.is_level);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any beat on either channel.
   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
      end
      if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("[tilt_bubble_position_unit] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      req_bus.valid   = 1'b0;
      req_bus.accel_x = '0;
      req_bus.accel_y = '0;
      req_bus.accel_z = '0;
      rsp_bus.ready   = 1'b0;
      origin_x_reg    = ORIGIN_X_RST;
      origin_y_reg    = ORIGIN_Y_RST;
      radius_reg      = TRAVEL_RADIUS_RST;
      threshold_reg   = LEVEL_THRESHOLD_RST;
      smooth_x        = 0;
      smooth_y        = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed samples under the reset register values.
      sample_queue.push_back(make_sample(0, 0, 0));
      sample_queue.push_back(make_sample(ACCEL_MAX, 0, 0));
      sample_queue.push_back(make_sample(ACCEL_MIN, 0, 0));
      sample_queue.push_back(make_sample(0, ACCEL_MAX, 0));
      sample_queue.push_back(make_sample(0, ACCEL_MIN, 0));
      sample_queue.push_back(make_sample(0, 0, ACCEL_MAX));
      sample_queue.push_back(make_sample(0, 0, ACCEL_MIN));
      sample_queue.push_back(make_sample(ACCEL_MIN, ACCEL_MIN, ACCEL_MIN));
      sample_queue.push_back(make_sample(ACCEL_MAX, ACCEL_MAX, ACCEL_MAX));
      sample_queue.push_back(make_sample(1, 0, 0));
      sample_queue.push_back(make_sample(0, -1, 0));
      sample_queue.push_back(make_sample(-1, 1, 0));
      sample_queue.push_back(make_sample(0, 0, 1));
      sample_queue.push_back(make_sample(0, 0, 0));
      sample_queue.push_back(make_sample(1000, -1000, 1000000));
      sample_queue.push_back(make_sample(-26000, 25000, 1000000));
      sample_queue.push_back(make_sample(27000, 0, 1000000));
      sample_queue.push_back(make_sample(ACCEL_MIN, ACCEL_MAX, 0));
      sample_queue.push_back(make_sample(32'sh5555_5555, -32'sh5555_5556, 32'sh1234_5678));
      sample_queue.push_back(make_sample(-32'sh5555_5556, 32'sh5555_5555, -32'sh1234_5678));
      wait_drained();

      // Register extremes: widest travel, never level, zero radius.
      program_bubble(0, 0, 255, 32768);
      queue_random(EXTREME_ITEMS);
      wait_drained();
      program_bubble(1023, 1023, 1, 0);
      queue_random(EXTREME_ITEMS);
      wait_drained();
      program_bubble(512, 300, 0, 65535);
      queue_random(EXTREME_ITEMS);
      wait_drained();

      // Random settings, one phase without any idling on either side.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_bubble($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(1, 255),
                        ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 32768));
         steady_run = (phase == STEADY_PHASE);
         queue_random(RANDOM_ITEMS);
         wait_drained();
      end
      steady_run = 1'b0;

      if (bubble_queue.size() != 0) begin
         $error("%0d positions never arrived", bubble_queue.size());
         fail_count++;
      end
      $display("Covered %0d samples (%0d all zero) over %0d register settings.",
               sample_beats, zero_samples, settings + 1);
      $display("Checked %0d positions, %0d of them flagged level.", bubble_beats, level_beats);
      if (fail_count == 0) begin
         $display("[tilt_bubble_position_unit] OK");
      end else begin
         $display("[tilt_bubble_position_unit] ERROR");
      end
      $finish;
   end

endmodule : tb_tilt_bubble_position_unit
